### src/spq_pkg.sv
package spq_pkg;

    // Input operation codes
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // Result status codes
    typedef logic [1:0] status_t;
    localparam status_t ST_ENQUEUED = 2'd0;
    localparam status_t ST_DROPPED  = 2'd1;
    localparam status_t ST_DEQUEUED = 2'd2;
    localparam status_t ST_EMPTY    = 2'd3;

    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 8;
    localparam int OCC_W   = 5;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [PRIO_W-1:0]         prio_t;

    // Row-wide move command, shared by every cell
    typedef struct packed {
        logic enq;   // insert the new entry at its sorted place
        logic deq;   // shift every entry one slot toward the head
    } ctrl_t;

endpackage

### src/spq_cell.sv
module spq_cell (
    input  logic            aclk,
    input  spq_pkg::ctrl_t  ctrl,
    input  logic            occupied,
    input  spq_pkg::value_t new_value,
    input  spq_pkg::prio_t  new_priority,
    input  spq_pkg::value_t left_value,
    input  spq_pkg::prio_t  left_priority,
    input  logic            left_ge,
    input  spq_pkg::value_t right_value,
    input  spq_pkg::prio_t  right_priority,
    output spq_pkg::value_t value,
    output spq_pkg::prio_t  priority_out,
    output logic            ge
);

    spq_pkg::value_t value_reg, value_next;
    spq_pkg::prio_t  prio_reg, prio_next;

    // This entry stays ahead of the new one when its priority is at least as high
    assign ge = occupied && (prio_reg >= new_priority);

    // Pick keep, take new, take left neighbor or take right neighbor
    always_comb begin
        value_next = value_reg;
        prio_next  = prio_reg;
        priority if (ctrl.enq) begin
            priority if (ge) begin
                value_next = value_reg;
                prio_next  = prio_reg;
            end else if (left_ge) begin
                value_next = new_value;
                prio_next  = new_priority;
            end else begin
                value_next = left_value;
                prio_next  = left_priority;
            end
        end else if (ctrl.deq) begin
            value_next = right_value;
            prio_next  = right_priority;
        end else begin
            // hold when idle
            value_next = value_reg;
            prio_next  = prio_reg;
        end
    end

    // Hold payload; no reset needed
    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign value        = value_reg;
    assign priority_out = prio_reg;

endmodule

### src/sorted_priority_queue.sv
// Sorted priority queue built as a row of DEPTH shift cells.
// The result is registered on the input transfer.
// Throughput: one item per cycle while the result is not stalled; every cell compares and shifts in the same cycle.
// A stalled result holds the input only until the output register frees up.
// Reset (aresetn low, synchronous) empties the queue and clears the output valid;
// cell contents are left as they are and are never read before being written.
module sorted_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_opcode,
    input  logic signed [31:0]  s_item_value,
    input  logic [7:0]          s_item_priority,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic signed [31:0]  m_out_value,
    output logic [4:0]          m_occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg;
    spq_pkg::status_t status_reg, status_next;
    spq_pkg::value_t  out_value_reg, out_value_next;
    logic [spq_pkg::OCC_W-1:0] occ_reg, occ_next;
    logic [CNT_W+spq_pkg::OCC_W-1:0] count_ext;

    logic            in_xfer;
    logic            full;
    logic            empty;
    spq_pkg::ctrl_t  ctrl;

    spq_pkg::value_t cell_value [DEPTH];
    spq_pkg::prio_t  cell_prio  [DEPTH];
    logic            cell_ge    [DEPTH];

    // Accept while the output register is empty or being drained
    assign s_ready = !m_valid_reg || m_ready;
    assign in_xfer = s_valid && s_ready;
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);

    assign ctrl.enq = in_xfer && (s_opcode == spq_pkg::OP_ENQUEUE) && !full;
    assign ctrl.deq = in_xfer && (s_opcode == spq_pkg::OP_DEQUEUE) && !empty;

    // Build the row of cells
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        spq_pkg::value_t left_value;
        spq_pkg::prio_t  left_prio;
        logic            left_ge;
        spq_pkg::value_t right_value;
        spq_pkg::prio_t  right_prio;

        if (i == 0) begin : g_head
            assign left_value = s_item_value;
            assign left_prio  = s_item_priority;
            assign left_ge    = 1'b1;
        end else begin : g_mid
            assign left_value = cell_value[i-1];
            assign left_prio  = cell_prio[i-1];
            assign left_ge    = cell_ge[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_value = cell_value[i];
            assign right_prio  = cell_prio[i];
        end else begin : g_body
            assign right_value = cell_value[i+1];
            assign right_prio  = cell_prio[i+1];
        end

        spq_cell u_cell (
            .aclk           (aclk),
            .ctrl           (ctrl),
            .occupied       (count_reg > CNT_W'(i)),
            .new_value      (s_item_value),
            .new_priority   (s_item_priority),
            .left_value     (left_value),
            .left_priority  (left_prio),
            .left_ge        (left_ge),
            .right_value    (right_value),
            .right_priority (right_prio),
            .value          (cell_value[i]),
            .priority_out   (cell_prio[i]),
            .ge             (cell_ge[i])
        );
    end

    // Next count and result fields
    always_comb begin
        count_next     = count_reg;
        status_next    = spq_pkg::ST_ENQUEUED;
        out_value_next = '0;
        unique case (s_opcode)
            spq_pkg::OP_ENQUEUE: begin
                if (full) begin
                    status_next = spq_pkg::ST_DROPPED;
                end else begin
                    status_next = spq_pkg::ST_ENQUEUED;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            spq_pkg::OP_DEQUEUE: begin
                if (empty) begin
                    status_next = spq_pkg::ST_EMPTY;
                end else begin
                    status_next    = spq_pkg::ST_DEQUEUED;
                    out_value_next = cell_value[0];
                    count_next     = count_reg - CNT_W'(1);
                end
            end
            default: begin
                status_next = spq_pkg::ST_ENQUEUED;
            end
        endcase
        count_ext = {{spq_pkg::OCC_W{1'b0}}, count_next};
        occ_next  = count_ext[spq_pkg::OCC_W-1:0];
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (in_xfer) begin
                count_reg <= count_next;
            end
            if (in_xfer) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            status_reg    <= status_next;
            out_value_reg <= out_value_next;
            occ_reg       <= occ_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = status_reg;
    assign m_out_value = out_value_reg;
    assign m_occupancy = occ_reg;

endmodule

### src/spq_checker.sv
module spq_checker #(
    parameter int DEPTH = 16
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [1:0]         m_status,
    input logic signed [31:0] m_out_value,
    input logic [4:0]         m_occupancy
);

    localparam logic [4:0] FULL_OCC = 5'(DEPTH);

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status)
            && $stable(m_out_value) && $stable(m_occupancy)))
        else $error("stalled result changed");

    // Drop only when full
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == spq_pkg::ST_DROPPED) |-> (m_occupancy == FULL_OCC))
        else $error("drop reported while not full");

    // Empty status only with nothing held
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == spq_pkg::ST_EMPTY) |-> (m_occupancy == 5'd0))
        else $error("empty status with entries held");

    // Only a dequeue returns a value
    a_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != spq_pkg::ST_DEQUEUED) |-> (m_out_value == '0))
        else $error("nonzero value without dequeue");

    // A successful enqueue leaves at least one entry
    a_enq_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == spq_pkg::ST_ENQUEUED) |-> (m_occupancy != 5'd0))
        else $error("enqueue left queue empty");

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_out_value (m_out_value),
    .m_occupancy (m_occupancy)
);

### test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 800;
    localparam int MAX_GAP      = 18;
    localparam int CYCLE_LIMIT  = 400000;

    // One result of the queue: status, dequeued value, occupancy after the item
    typedef struct {
        spq_pkg::status_t          status;
        spq_pkg::value_t           value;
        logic [spq_pkg::OCC_W-1:0] occ;
    } reply_t;

    // One line of the directed plan; fixed rows carry their reply typed in
    typedef struct {
        logic            op;
        spq_pkg::value_t value;
        spq_pkg::prio_t  prio;
        bit              fixed;
        reply_t          reply;
    } plan_row_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_opcode;
    spq_pkg::value_t           s_item_value;
    spq_pkg::prio_t            s_item_priority;
    logic                      m_valid;
    logic                      m_ready;
    logic [1:0]                m_status;
    spq_pkg::value_t           m_out_value;
    logic [spq_pkg::OCC_W-1:0] m_occupancy;

    // Shadow copy of the sorted array, highest priority at index 0
    spq_pkg::value_t shadow_value [DEPTH];
    spq_pkg::prio_t  shadow_prio  [DEPTH];
    int              shadow_count;

    reply_t    awaited_replies[$];
    plan_row_t plan[$];

    bit     row_fixed;
    reply_t row_reply;
    bit     tx_fast;
    bit     rx_fast;
    int     rx_hold;
    int     mismatch_count;
    int     accepted_count;
    int     reply_count;
    int     status_seen[4];
    int     cycle_count;

    spq_pkg::value_t dir_value[DEPTH] = '{32'sh7fffffff, 32'sh80000000, 32'sh0, -32'sd1,
                                          32'sd1, 32'sh55555555, 32'shaaaaaaaa, 32'sd2,
                                          32'sd3, 32'sd4, 32'sd5, 32'sd6,
                                          32'sd7, 32'sd8, 32'sd9, 32'sd10};
    spq_pkg::prio_t  dir_prio[DEPTH]  = '{8'd255, 8'd0, 8'd128, 8'd128, 8'd128, 8'd1,
                                          8'd254, 8'd0, 8'd255, 8'd7, 8'd128, 8'd0,
                                          8'd255, 8'd64, 8'd128, 8'd1};

    sorted_priority_queue #(
        .DEPTH(DEPTH)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_item_value    (s_item_value),
        .s_item_priority (s_item_priority),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_out_value     (m_out_value),
        .m_occupancy     (m_occupancy)
    );

    // 12 ns clock
    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Apply one queue operation to the shadow array and return its reply
    function automatic reply_t apply_queue_op(logic op, spq_pkg::value_t value,
                                              spq_pkg::prio_t prio);
        reply_t r;
        int     pos;
        int     i;
        r.value = '0;
        if (op == spq_pkg::OP_ENQUEUE) begin
            if (shadow_count >= DEPTH) begin
                r.status = spq_pkg::ST_DROPPED;
            end else begin
                // insert behind every entry of equal or higher priority
                pos = 0;
                while (pos < shadow_count && shadow_prio[pos] >= prio) pos++;
                for (i = shadow_count; i > pos; i--) begin
                    shadow_value[i] = shadow_value[i-1];
                    shadow_prio[i]  = shadow_prio[i-1];
                end
                shadow_value[pos] = value;
                shadow_prio[pos]  = prio;
                shadow_count++;
                r.status = spq_pkg::ST_ENQUEUED;
            end
        end else begin
            if (shadow_count == 0) begin
                r.status = spq_pkg::ST_EMPTY;
            end else begin
                // pop the head and close the gap
                r.value = shadow_value[0];
                for (i = 0; i + 1 < shadow_count; i++) begin
                    shadow_value[i] = shadow_value[i+1];
                    shadow_prio[i]  = shadow_prio[i+1];
                end
                shadow_count--;
                r.status = spq_pkg::ST_DEQUEUED;
            end
        end
        r.occ = spq_pkg::OCC_W'(shadow_count);
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic plan_row_t make_row(logic op, spq_pkg::value_t value,
                                           spq_pkg::prio_t prio,
                                           bit fixed, reply_t reply);
        plan_row_t row;
        row.op    = op;
        row.value = value;
        row.prio  = prio;
        row.fixed = fixed;
        row.reply = reply;
        return row;
    endfunction

    // Offer one item after a random gap, or none when tx_fast is set, and hold it until the transfer
    task automatic send_item(plan_row_t row);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid         <= 1'b1;
        s_opcode        <= row.op;
        s_item_value    <= row.value;
        s_item_priority <= row.prio;
        row_fixed = row.fixed;
        row_reply = row.reply;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Hold off the sender until every awaited reply has come back
    task automatic wait_for_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (awaited_replies.size() != 0) @(negedge aclk);
    endtask

    // Predict on every input transfer, check on every result transfer
    always @(posedge aclk) begin
        reply_t want;
        reply_t got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got.status = m_status;
                got.value  = m_out_value;
                got.occ    = m_occupancy;
                reply_count++;
                if (awaited_replies.size() == 0) begin
                    report_mismatch($sformatf("result with nothing awaited: status %0h value %0h",
                                              got.status, got.value));
                end else begin
                    want = awaited_replies.pop_front();
                    status_seen[want.status]++;
                    if (got.status !== want.status)
                        report_mismatch($sformatf("reply %0d status: got %0h, want %0h",
                                                  reply_count, got.status, want.status));
                    if (got.value !== want.value)
                        report_mismatch($sformatf("reply %0d out_value: got %0h, want %0h",
                                                  reply_count, got.value, want.value));
                    if (got.occ !== want.occ)
                        report_mismatch($sformatf("reply %0d occupancy: got %0d, want %0d",
                                                  reply_count, got.occ, want.occ));
                end
                if (reply_count % 64 == 0) rx_fast = ($urandom_range(0, 3) == 0);
                rx_hold = rx_fast ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (s_valid && s_ready) begin
                want = apply_queue_op(s_opcode, s_item_value, s_item_priority);
                if (row_fixed) want = row_reply;
                awaited_replies.push_back(want);
                accepted_count++;
            end
        end
    end

    // Stall the result side for the drawn number of cycles after each transfer
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin
        plan_row_t row;
        int        sent_random;
        int        burst_len;
        int        enq_pct;
        bit        narrow;
        int        k;

        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_opcode        = spq_pkg::OP_ENQUEUE;
        s_item_value    = '0;
        s_item_priority = '0;
        m_ready         = 1'b0;
        rx_hold         = 0;
        rx_fast         = 1'b0;
        tx_fast         = 1'b0;
        row_fixed       = 1'b0;
        shadow_count    = 0;

        // Directed plan: empty dequeue, fill with extremes and ties, full drop, drain part
        plan.push_back(make_row(spq_pkg::OP_DEQUEUE, 32'sh7fffffff, 8'd255, 1'b1,
                                '{spq_pkg::ST_EMPTY, '0, '0}));
        for (k = 0; k < DEPTH; k++)
            plan.push_back(make_row(spq_pkg::OP_ENQUEUE, dir_value[k], dir_prio[k], 1'b1,
                                    '{spq_pkg::ST_ENQUEUED, '0,
                                      spq_pkg::OCC_W'(k + 1)}));
        plan.push_back(make_row(spq_pkg::OP_ENQUEUE, 32'sh80000000, 8'd255, 1'b1,
                                '{spq_pkg::ST_DROPPED, '0, spq_pkg::OCC_W'(DEPTH)}));
        for (k = 0; k < 7; k++)
            plan.push_back(make_row(spq_pkg::OP_DEQUEUE, spq_pkg::value_t'($urandom),
                                    spq_pkg::prio_t'($urandom), 1'b0,
                                    '{spq_pkg::ST_EMPTY, '0, '0}));

        // Hold reset low before releasing it
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) send_item(plan[i]);
        wait_for_drain();

        // Random bursts with a drifting enqueue bias to sweep full and empty
        sent_random = 0;
        row.fixed   = 1'b0;
        row.reply   = '{spq_pkg::ST_EMPTY, '0, '0};
        while (sent_random < RANDOM_ITEMS) begin
            burst_len = $urandom_range(8, 60);
            case ($urandom_range(0, 3))
                0:       enq_pct = 85;
                1:       enq_pct = 15;
                2:       enq_pct = 50;
                default: enq_pct = 60;
            endcase
            narrow  = ($urandom_range(0, 1) == 1);
            tx_fast = ($urandom_range(0, 3) == 0);
            for (k = 0; k < burst_len && sent_random < RANDOM_ITEMS; k++) begin
                row.op = ($urandom_range(0, 99) < enq_pct) ? spq_pkg::OP_ENQUEUE
                                                           : spq_pkg::OP_DEQUEUE;
                if ($urandom_range(0, 9) == 0) begin
                    case ($urandom_range(0, 3))
                        0:       row.value = 32'sh80000000;
                        1:       row.value = 32'sh7fffffff;
                        2:       row.value = '0;
                        default: row.value = -32'sd1;
                    endcase
                end else begin
                    row.value = spq_pkg::value_t'($urandom);
                end
                if (narrow)
                    row.prio = $urandom_range(0, 1)
                               ? spq_pkg::prio_t'($urandom_range(0, 3))
                               : spq_pkg::prio_t'($urandom_range(252, 255));
                else
                    row.prio = spq_pkg::prio_t'($urandom_range(0, 255));
                send_item(row);
                sent_random++;
            end
            if ($urandom_range(0, 4) == 0) wait_for_drain();
        end

        // Wind down: wait for the last replies, then flag any still awaited
        @(negedge aclk);
        s_valid <= 1'b0;
        while (awaited_replies.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        while (awaited_replies.size() != 0) begin
            void'(awaited_replies.pop_front());
            report_mismatch("reply still awaited at end of run");
        end

        $display("summary: %0d items sent (%0d directed), %0d replies checked",
                 accepted_count, plan.size(), reply_count);
        $display("summary: enqueued %0d, dropped on full %0d, dequeued %0d, empty dequeue %0d",
                 status_seen[spq_pkg::ST_ENQUEUED], status_seen[spq_pkg::ST_DROPPED],
                 status_seen[spq_pkg::ST_DEQUEUED], status_seen[spq_pkg::ST_EMPTY]);
        if (mismatch_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
